>>> src/rmd_pkg.sv
`timescale 1ns / 1ps

package rmd_pkg;

  // queue geometry
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MSG_BYTES = 4;

  localparam int unsigned IdxW     = $clog2(DEPTH);
  localparam int unsigned OpW      = 2;
  localparam int unsigned TaskW    = 8;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned StatusW  = 2;

  // payload bits kept in a slot
  localparam int unsigned KeepW    = (8 * MSG_BYTES < PayloadW) ? 8 * MSG_BYTES : PayloadW;
  localparam int unsigned EntryW   = TaskW + KeepW;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);

  // operation codes
  localparam logic [OpW-1:0] OpAppend = 2'd0;
  localparam logic [OpW-1:0] OpInsert = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;
  localparam logic [OpW-1:0] OpClear  = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic               push_tail;
    logic               push_head;
    logic               pop;
    logic               clear;
    logic               load_result;
    logic [StatusW-1:0] status;
  } rmd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } rmd_stat_t;

endpackage

>>> src/rmd_ctrl.sv
`timescale 1ns / 1ps

module rmd_ctrl import rmd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rmd_stat_t      stat_i,
  output rmd_cmd_t       cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StOut  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign accept      = in_valid_i && in_ready_o;

  // decode the accepted beat into datapath commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.load_result = accept;
    cmd_o.status      = StDone;
    case (op_i)
      OpAppend: begin
        if (stat_i.full) cmd_o.status = StFull;
        else             cmd_o.push_tail = accept;
      end
      OpInsert: begin
        if (stat_i.full) cmd_o.status = StFull;
        else             cmd_o.push_head = accept;
      end
      OpRemove: begin
        if (stat_i.empty) cmd_o.status = StEmpty;
        else              cmd_o.pop = accept;
      end
      OpClear: begin
        cmd_o.clear = accept;
      end
      default: begin
        cmd_o.status = StDone;
      end
    endcase
  end

  // one item in flight: accept, then hold the result until taken
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

>>> src/rmd_datapath.sv
`timescale 1ns / 1ps

module rmd_datapath import rmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmd_cmd_t            cmd_i,
  input  logic [TaskW-1:0]    task_id_i,
  input  logic [PayloadW-1:0] payload_i,
  output rmd_stat_t           stat_o,
  output logic [StatusW-1:0]  status_o,
  output logic [TaskW-1:0]    out_task_id_o,
  output logic [PayloadW-1:0] out_payload_o
);

  logic [IdxW-1:0]    front_q, front_d, rear_q, rear_d;
  logic [IdxW-1:0]    front_inc, front_dec, rear_inc, wr_idx;
  logic [EntryW-1:0]  mem [DEPTH];
  logic [EntryW-1:0]  rd_q;
  logic [StatusW-1:0] status_q;
  logic               pop_ok_q;
  logic               we;

  // modulo neighbors of the indices
  assign front_inc = (front_q == IdxLast) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxLast : front_q - 1'b1;
  assign rear_inc  = (rear_q == IdxLast) ? '0 : rear_q + 1'b1;

  assign stat_o.full  = (rear_inc == front_q);
  assign stat_o.empty = (rear_q == front_q);

  // index updates
  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    if (cmd_i.clear) begin
      front_d = '0;
      rear_d  = '0;
    end else if (cmd_i.push_tail) begin
      rear_d = rear_inc;
    end else if (cmd_i.push_head) begin
      front_d = front_dec;
    end else if (cmd_i.pop) begin
      front_d = front_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

  // slot store: tail push writes ahead of rear, head push writes at front
  assign we     = cmd_i.push_tail || cmd_i.push_head;
  assign wr_idx = cmd_i.push_tail ? rear_inc : front_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_idx] <= {task_id_i, payload_i[KeepW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) rd_q <= mem[front_inc];
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= StDone;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      status_q <= cmd_i.status;
      pop_ok_q <= cmd_i.pop;
    end
  end

  assign status_o      = status_q;
  assign out_task_id_o = pop_ok_q ? rd_q[EntryW-1:KeepW] : '0;
  assign out_payload_o = pop_ok_q ? PayloadW'(rd_q[KeepW-1:0]) : '0;

endmodule

>>> src/ring_message_deque_top.sv
`timescale 1ns / 1ps
// result: a result beat is offered in the cycle after its input beat is accepted
// flow: the controller holds a single item at a time; the next input beat is taken
// in the cycle after the result beat leaves
// reset: rst_ni asynchronous active low empties the queue (front and rear at
// zero); slot contents are not cleared and are only read once written

module ring_message_deque_top import rmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [TaskW-1:0]    task_id_i,
  input  logic [PayloadW-1:0] payload_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [TaskW-1:0]    out_task_id_o,
  output logic [PayloadW-1:0] out_payload_o
);

  rmd_cmd_t  cmd;
  rmd_stat_t stat;

  // controller
  rmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // indices, slot store and result registers
  rmd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .task_id_i     (task_id_i),
    .payload_i     (payload_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .out_task_id_o (out_task_id_o),
    .out_payload_o (out_payload_o)
  );

endmodule

>>> tb/ring_message_deque_top_tb.sv
`timescale 1ns / 1ps

module ring_message_deque_top_tb;
  import rmd_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [StatusW-1:0]  status;
    logic [TaskW-1:0]    task_id;
    logic [PayloadW-1:0] payload;
  } deque_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OpW-1:0]      op_i;
  logic [TaskW-1:0]    task_id_i;
  logic [PayloadW-1:0] payload_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StatusW-1:0]  status_o;
  logic [TaskW-1:0]    out_task_id_o;
  logic [PayloadW-1:0] out_payload_o;

  // shadow copy of the deque
  logic [EntryW-1:0] shadow_slots [DEPTH];
  logic [IdxW-1:0]   shadow_front;
  logic [IdxW-1:0]   shadow_rear;

  deque_result_t pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  ring_message_deque_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .task_id_i     (task_id_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_task_id_o (out_task_id_o),
    .out_payload_o (out_payload_o)
  );

  always #5 clk_i = ~clk_i;

  // ring index helpers
  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    return (idx == IdxLast) ? '0 : idx + 1'b1;
  endfunction

  function automatic int entries_held();
    if (shadow_rear >= shadow_front) begin
      return int'(shadow_rear) - int'(shadow_front);
    end
    return int'(shadow_rear) + DEPTH - int'(shadow_front);
  endfunction

  // apply one operation to the shadow deque and return its result
  function automatic deque_result_t apply_deque_op(input logic [OpW-1:0] op,
                                                   input logic [TaskW-1:0] tid,
                                                   input logic [PayloadW-1:0] pl);
    deque_result_t res;
    logic          is_full;
    logic          is_empty;
    logic [EntryW-1:0] entry;
    res.status  = StDone;
    res.task_id = '0;
    res.payload = '0;
    is_full  = (ring_next(shadow_rear) == shadow_front);
    is_empty = (shadow_rear == shadow_front);
    entry    = {tid, pl[KeepW-1:0]};
    case (op)
      OpAppend: begin
        if (is_full) begin
          res.status = StFull;
        end else begin
          shadow_rear = ring_next(shadow_rear);
          shadow_slots[shadow_rear] = entry;
        end
      end
      OpInsert: begin
        if (is_full) begin
          res.status = StFull;
        end else begin
          shadow_slots[shadow_front] = entry;
          shadow_front = (shadow_front == '0) ? IdxLast : shadow_front - 1'b1;
        end
      end
      OpRemove: begin
        if (is_empty) begin
          res.status = StEmpty;
        end else begin
          shadow_front = ring_next(shadow_front);
          entry = shadow_slots[shadow_front];
          res.task_id = entry[EntryW-1 -: TaskW];
          res.payload = PayloadW'(entry[KeepW-1:0]);
        end
      end
      default: begin
        shadow_front = '0;
        shadow_rear  = '0;
      end
    endcase
    return res;
  endfunction

  // offer one input beat, hold it until taken, then record its expectation
  task automatic send_item(input logic [OpW-1:0] op, input logic [TaskW-1:0] tid,
                           input logic [PayloadW-1:0] pl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      op_i       <= OpW'($urandom_range(0, 3));
      task_id_i  <= TaskW'($urandom());
      payload_i  <= $urandom();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    task_id_i  <= tid;
    payload_i  <= pl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_deque_op(op, tid, pl));
  endtask

  task automatic send_random(input logic [OpW-1:0] op);
    send_item(op, TaskW'($urandom()), $urandom());
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat status=%0d task=%02h payload=%08h",
                                status_o, out_task_id_o, out_payload_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || out_task_id_o !== want.task_id ||
            out_payload_o !== want.payload) begin
          note_mismatch($sformatf(
            "expected status=%0d task=%02h payload=%08h, got status=%0d task=%02h payload=%08h",
            want.status, want.task_id, want.payload,
            status_o, out_task_id_o, out_payload_o));
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("ring_message_deque_top_tb failed");
        $finish;
      end
    end
  end

  // result receiver with random stalls and a requested long hold-off
  initial begin : receiver
    int hold_left;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
        repeat (hold_left) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // extremes, every operation, wrap of the front index, clear and empty removes
  task automatic test_directed();
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpAppend, 8'hFF, 32'hFFFF_FFFF);
    send_item(OpInsert, 8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'hFF, 32'hFFFF_FFFF);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpInsert, 8'h5A, 32'hA5A5_A5A5);
    send_item(OpInsert, 8'hA5, 32'h5A5A_5A5A);
    send_item(OpAppend, 8'h01, 32'h0000_0001);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpAppend, 8'h80, 32'h8000_0000);
    send_item(OpAppend, 8'h7F, 32'h7FFF_FFFF);
    send_item(OpClear,  8'hFF, 32'hFFFF_FFFF);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpAppend, 8'h3C, 32'h1234_5678);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
    send_item(OpClear,  8'h00, 32'h0000_0000);
    send_item(OpRemove, 8'h00, 32'h0000_0000);
  endtask

  // fill with mixed pushes until full, then push into the full queue, with removes between
  task automatic test_fill_to_full();
    while (entries_held() < DEPTH - 1) begin
      send_random($urandom_range(0, 1) ? OpAppend : OpInsert);
    end
    send_random(OpAppend);
    send_random(OpInsert);
    send_random(OpRemove);
    send_random(OpInsert);
    send_random(OpAppend);
    send_random(OpRemove);
    send_random(OpAppend);
    send_random(OpInsert);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_request = HoldCycles;
    repeat (30) begin
      send_random(OpW'($urandom_range(0, 2)));
    end
  endtask

  // random traffic with rare clears that drifts between growing and shrinking the queue
  task automatic test_random_traffic(input int n_items);
    logic grow;
    int   held;
    int   pick;
    grow = 1'($urandom_range(0, 1));
    repeat (n_items) begin
      held = entries_held();
      if (held == DEPTH - 1 && $urandom_range(0, 3) == 0) begin
        grow = 1'b0;
      end else if (held == 0 && $urandom_range(0, 3) == 0) begin
        grow = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        grow = ~grow;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_random(OpClear);
      end else if (pick < (grow ? 80 : 30)) begin
        send_random($urandom_range(0, 1) ? OpAppend : OpInsert);
      end else begin
        send_random(OpRemove);
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = OpAppend;
    task_id_i  = '0;
    payload_i  = '0;
    shadow_front = '0;
    shadow_rear  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_fill_to_full();
    test_backpressure();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(140);
    send_idle_pct  = 79;
    recv_stall_pct = 0;
    test_random_traffic(140);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    test_random_traffic(140);
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    test_random_traffic(140);

    // drain and let the last result settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ring_message_deque_top_tb passed");
    end else begin
      $display("ring_message_deque_top_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rmd_pkg.sv
src/rmd_ctrl.sv
src/rmd_datapath.sv
src/ring_message_deque_top.sv
tb/ring_message_deque_top_tb.sv
